// File: src/sbda_pkg.sv
// shared constants and types for the signed binary to decimal text converter
`timescale 1ns / 1ps
`default_nettype none
package sbda_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CHAR_W = 6;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 6'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

endpackage
`default_nettype wire

// File: src/sbda_channels.sv
// valid/ready channel interfaces for the number input and character output
`timescale 1ns / 1ps
`default_nettype none
interface sbda_req_if #(
   parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbda_pkg::CHAR_W-1:0] character;
   logic                        last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: src/sbda_dabble.sv
// one shift-add-3 step of the binary to bcd conversion
`timescale 1ns / 1ps
`default_nettype none
module sbda_dabble #(
   parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT,
   parameter int NUM_DIGITS = 10
) (
   input  wire logic [4*NUM_DIGITS-1:0] bcd,
   input  wire logic [VALUE_BITS-1:0]   bin,
   output logic      [4*NUM_DIGITS-1:0] bcd_next,
   output logic      [VALUE_BITS-1:0]   bin_next
);

   logic [4*NUM_DIGITS-1:0] adjusted;

   // digits of five or more get three added before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd[4*d +: 4];
         end
      end
   end

   assign bcd_next = {adjusted[4*NUM_DIGITS-2:0], bin[VALUE_BITS-1]};
   assign bin_next = {bin[VALUE_BITS-2:0], 1'b0};

endmodule
`default_nettype wire

// File: src/signed_binary_to_decimal_ascii.sv
// signed binary to decimal ascii text converter, top level
//
// usage:
//  - req carries one signed VALUE_BITS-bit number per transaction; req.ready
//    is high only while the converter is idle
//  - rsp carries the text, one ascii character per transaction: '-' for a
//    negative number, then the magnitude's digits most significant first with
//    no leading zeros; rsp.last marks the final character
//  - the most negative value prints as its unsigned magnitude after '-'
// timing:
//  - the single shift-add-3 step is applied once for each of the VALUE_BITS bits (32 at default)
//  - leading zero digits are dropped one per cycle, up to NUM_DIGITS-1
//  - then one character per cycle while rsp is not stalled
//  - a number passes through the bit-serial dabble step, the zero strip and the
//    digit shifter in turn; a new number is taken only once the last character
//    of the previous one is in the output register
// reset: synchronous, clears the sequencer and the output valid
// stall: a character waits in the output register until rsp.ready; the
//  sequencer holds until the register frees, no character is lost
`timescale 1ns / 1ps
`default_nettype none
module signed_binary_to_decimal_ascii #(
   parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   sbda_req_if.sink  req,
   sbda_rsp_if.source rsp
);

   // digits in 2^(VALUE_BITS-1), worked out at elaboration
   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W = 4 * NUM_DIGITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_W = $clog2(NUM_DIGITS + 1);

   sbda_pkg::state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      bits_left_ff, bits_left_in;
   logic [DIG_W-1:0]      digits_left_ff, digits_left_in;
   logic                  neg_ff, neg_in;

   logic                        out_valid_ff, out_valid_in;
   logic [sbda_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;

   logic [BCD_W-1:0]      bcd_step;
   logic [VALUE_BITS-1:0] bin_step;
   logic [3:0]            top_digit;
   logic                  accept;
   logic                  out_free;
   logic                  final_digit;

   sbda_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .bcd      (bcd_ff),
      .bin      (bin_ff),
      .bcd_next (bcd_step),
      .bin_next (bin_step)
   );

   assign accept      = req.valid && req.ready;
   assign out_free    = !out_valid_ff || rsp.ready;
   assign top_digit   = bcd_ff[BCD_W-1 -: 4];
   assign final_digit = (digits_left_ff == DIG_W'(1));

   assign req.ready     = (state_ff == sbda_pkg::ST_IDLE);
   assign rsp.valid     = out_valid_ff;
   assign rsp.character = out_char_ff;
   assign rsp.last      = out_last_ff;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbda_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sbda_pkg::ST_CONVERT;
            end
         end
         sbda_pkg::ST_CONVERT: begin
            if (bits_left_ff == CNT_W'(1)) begin
               state_in = sbda_pkg::ST_STRIP;
            end
         end
         sbda_pkg::ST_STRIP: begin
            // stop at the first nonzero digit, always keep the units digit
            if (top_digit != 4'd0 || final_digit) begin
               state_in = neg_ff ? sbda_pkg::ST_SIGN : sbda_pkg::ST_DIGITS;
            end
         end
         sbda_pkg::ST_SIGN: begin
            if (out_free) begin
               state_in = sbda_pkg::ST_DIGITS;
            end
         end
         sbda_pkg::ST_DIGITS: begin
            if (out_free && final_digit) begin
               state_in = sbda_pkg::ST_IDLE;
            end
         end
         default: state_in = sbda_pkg::ST_IDLE;
      endcase
   end

   // datapath and output register controls
   always_comb begin
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      bits_left_in   = bits_left_ff;
      digits_left_in = digits_left_ff;
      neg_in         = neg_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_char_in    = out_char_ff;
      out_last_in    = out_last_ff;
      unique case (state_ff)
         sbda_pkg::ST_IDLE: begin
            if (accept) begin
               // magnitude as unsigned, so the most negative value stays exact
               neg_in         = req.value[VALUE_BITS-1];
               bin_in         = req.value[VALUE_BITS-1] ? (~req.value + 1'b1)
                                                        : req.value;
               bcd_in         = '0;
               bits_left_in   = CNT_W'(VALUE_BITS);
               digits_left_in = DIG_W'(NUM_DIGITS);
            end
         end
         sbda_pkg::ST_CONVERT: begin
            bcd_in       = bcd_step;
            bin_in       = bin_step;
            bits_left_in = bits_left_ff - 1'b1;
         end
         sbda_pkg::ST_STRIP: begin
            if (top_digit == 4'd0 && !final_digit) begin
               bcd_in         = {bcd_ff[BCD_W-5:0], 4'd0};
               digits_left_in = digits_left_ff - 1'b1;
            end
         end
         sbda_pkg::ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = sbda_pkg::CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         sbda_pkg::ST_DIGITS: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_char_in    = sbda_pkg::CHAR_ZERO + {2'b00, top_digit};
               out_last_in    = final_digit;
               bcd_in         = {bcd_ff[BCD_W-5:0], 4'd0};
               digits_left_in = digits_left_ff - 1'b1;
            end
         end
         default: begin
            out_valid_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbda_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bin_ff         <= bin_in;
      bcd_ff         <= bcd_in;
      bits_left_ff   <= bits_left_in;
      digits_left_ff <= digits_left_in;
      neg_ff         <= neg_in;
      out_char_ff    <= out_char_in;
      out_last_ff    <= out_last_in;
   end

   // a character left pending while idle must close the previous text
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbda_pkg::ST_IDLE && out_valid_ff) |-> out_last_ff)
      else $error("idle with a non-final character pending");

   // an accepted number always starts a conversion
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sbda_pkg::ST_CONVERT))
      else $error("accepted number did not start conversion");

   // emitting digits never runs past the units digit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbda_pkg::ST_DIGITS) |-> (digits_left_ff != '0))
      else $error("digit counter underflow");

   // every character shown is a minus sign or a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_char_ff == sbda_pkg::CHAR_MINUS ||
                        (out_char_ff >= sbda_pkg::CHAR_ZERO &&
                         out_char_ff <= sbda_pkg::CHAR_NINE)))
      else $error("character out of range");

   // the output register changes only when it is free to be reloaded
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> ($stable(out_char_ff) && out_valid_ff))
      else $error("stalled character overwritten");

endmodule
`default_nettype wire
